// File: rtl/core/eswm_pkg.sv
// Shared types, constants and arithmetic helpers for the SRT world matrix block.
// Used by eswm_trig, eswm_mat and euler_srt_world_matrix; depends on nothing.
package eswm_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int CORDIC_STEPS   = 30;

  // Trig values span [-1, 1], so they need two integer bits above the fraction.
  localparam int TW = TRIG_FRAC_BITS + 2;
  // Sums of two trig products.
  localparam int RW = TW + 1;
  // Scale times row value, with one bit of headroom for rounding.
  localparam int PW = 16 + RW + 1;

  localparam int TSH = 30 - TRIG_FRAC_BITS;
  localparam int SSH = TRIG_FRAC_BITS - 8;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

  // Arctangent of 2^-i in units of 2^32 per turn.
  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  typedef struct packed {
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
    logic [15:0]        angle_x;
    logic [15:0]        angle_y;
    logic [15:0]        angle_z;
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
    logic signed [31:0] move_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] out_move_x;
    logic signed [31:0] out_move_y;
    logic signed [31:0] out_move_z;
  } out_t;

  typedef struct packed {
    logic signed [TW-1:0] cx;
    logic signed [TW-1:0] sx;
    logic signed [TW-1:0] cy;
    logic signed [TW-1:0] sy;
    logic signed [TW-1:0] cz;
    logic signed [TW-1:0] sz;
  } trig_t;

  // Round a Q2.30 CORDIC output half up to the trig fraction and clamp to [-1, 1].
  function automatic logic signed [TW-1:0] trig_round(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [34:0] one;
    t   = 35'(v);
    one = 35'sd1 <<< TRIG_FRAC_BITS;
    if (TSH > 0) begin
      t = (t + (35'sd1 <<< ((TSH > 0) ? TSH - 1 : 0))) >>> TSH;
    end
    if (t > one) begin
      t = one;
    end else if (t < -one) begin
      t = -one;
    end
    return TW'(t);
  endfunction

  // Product of two trig values, rounded half up back to the trig fraction.
  function automatic logic signed [TW-1:0] mulq(input logic signed [TW-1:0] a,
                                                 input logic signed [TW-1:0] b);
    logic signed [2*TW-1:0] p;
    p = (2*TW)'(a) * (2*TW)'(b);
    p = (p + ((2*TW)'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
    return TW'(p);
  endfunction

  // Round a scaled product to Q16.16 and saturate to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    logic signed [63:0]   w;
    t = p;
    if (SSH > 0) begin
      t = (t + (PW'(1) <<< ((SSH > 0) ? SSH - 1 : 0))) >>> SSH;
    end
    w = 64'(t);
    if (w > 64'sd2147483647) begin
      w = 64'sd2147483647;
    end else if (w < -64'sd2147483648) begin
      w = -64'sd2147483648;
    end
    return w[31:0];
  endfunction

endpackage

// File: rtl/core/eswm_trig.sv
// Pipelined CORDIC for the three Euler angles: one rotation step per stage,
// then a quadrant fold and rounding stage. Depends on eswm_pkg.
module eswm_trig (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  eswm_pkg::in_t   in_data,
  output logic            out_valid,
  output eswm_pkg::trig_t out_trig,
  output eswm_pkg::in_t   out_data
);

  localparam int N    = eswm_pkg::CORDIC_STEPS;
  localparam int TW_L = eswm_pkg::TW;

  logic signed [33:0] x_r [3][N];
  logic signed [33:0] y_r [3][N];
  logic signed [32:0] z_r [3][N];
  logic [1:0]         q_r [3][N];
  eswm_pkg::in_t      d_r [N];
  logic [N-1:0]       v_r;

  logic signed [33:0] x_nxt [3][N];
  logic signed [33:0] y_nxt [3][N];
  logic signed [32:0] z_nxt [3][N];
  logic [1:0]         q_nxt [3][N];

  logic [31:0]        turn [3];
  logic signed [33:0] c_fold [3];
  logic signed [33:0] s_fold [3];
  logic signed [TW_L-1:0] c_out [3];
  logic signed [TW_L-1:0] s_out [3];

  eswm_pkg::trig_t trig_r;
  eswm_pkg::in_t   dout_r;
  logic            vout_r;

  // Widen each angle to a 32-bit turn.
  always_comb begin
    turn[0] = 32'((32'(in_data.angle_x) & eswm_pkg::ANGLE_MASK) << (32 - eswm_pkg::ANGLE_BITS));
    turn[1] = 32'((32'(in_data.angle_y) & eswm_pkg::ANGLE_MASK) << (32 - eswm_pkg::ANGLE_BITS));
    turn[2] = 32'((32'(in_data.angle_z) & eswm_pkg::ANGLE_MASK) << (32 - eswm_pkg::ANGLE_BITS));
  end

  // One micro-rotation per stage; stage i shifts by i.
  always_comb begin
    logic signed [33:0] xp;
    logic signed [33:0] yp;
    logic signed [32:0] zp;
    logic signed [32:0] at;
    for (int a = 0; a < 3; a++) begin
      for (int i = 0; i < N; i++) begin
        if (i == 0) begin
          xp         = eswm_pkg::CORDIC_GAIN;
          yp         = '0;
          zp         = {3'b000, turn[a][29:0]};
          q_nxt[a][i] = turn[a][31:30];
        end else begin
          xp         = x_r[a][i-1];
          yp         = y_r[a][i-1];
          zp         = z_r[a][i-1];
          q_nxt[a][i] = q_r[a][i-1];
        end
        at = $signed({1'b0, eswm_pkg::ATAN_TURN[i]});
        if (!zp[32]) begin
          x_nxt[a][i] = xp - (yp >>> i);
          y_nxt[a][i] = yp + (xp >>> i);
          z_nxt[a][i] = zp - at;
        end else begin
          x_nxt[a][i] = xp + (yp >>> i);
          y_nxt[a][i] = yp - (xp >>> i);
          z_nxt[a][i] = zp + at;
        end
      end
    end
  end

  // Fold the first-quadrant result into the full circle and round.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      unique case (q_r[a][N-1])
        2'd0: begin
          c_fold[a] = x_r[a][N-1];
          s_fold[a] = y_r[a][N-1];
        end
        2'd1: begin
          c_fold[a] = -y_r[a][N-1];
          s_fold[a] = x_r[a][N-1];
        end
        2'd2: begin
          c_fold[a] = -x_r[a][N-1];
          s_fold[a] = -y_r[a][N-1];
        end
        default: begin
          c_fold[a] = y_r[a][N-1];
          s_fold[a] = -x_r[a][N-1];
        end
      endcase
      c_out[a] = eswm_pkg::trig_round(c_fold[a]);
      s_out[a] = eswm_pkg::trig_round(s_fold[a]);
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < N; i++) begin
          x_r[a][i] <= x_nxt[a][i];
          y_r[a][i] <= y_nxt[a][i];
          z_r[a][i] <= z_nxt[a][i];
          q_r[a][i] <= q_nxt[a][i];
        end
      end
      d_r[0] <= in_data;
      for (int i = 1; i < N; i++) begin
        d_r[i] <= d_r[i-1];
      end
      trig_r.cx <= c_out[0];
      trig_r.sx <= s_out[0];
      trig_r.cy <= c_out[1];
      trig_r.sy <= s_out[1];
      trig_r.cz <= c_out[2];
      trig_r.sz <= s_out[2];
      dout_r    <= d_r[N-1];
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= '0;
      vout_r <= 1'b0;
    end else if (en) begin
      v_r    <= {v_r[N-2:0], in_valid};
      vout_r <= v_r[N-1];
    end
  end

  assign out_valid = vout_r;
  assign out_trig  = trig_r;
  assign out_data  = dout_r;

endmodule

// File: rtl/core/eswm_mat.sv
// Matrix assembly pipeline: trig products, triple products, sums, scaling and
// saturation, one register stage each. Depends on eswm_pkg.
module eswm_mat (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  eswm_pkg::trig_t in_trig,
  input  eswm_pkg::in_t   in_data,
  output logic            out_valid,
  output eswm_pkg::out_t  out_data
);

  localparam int TW = eswm_pkg::TW;
  localparam int RW = eswm_pkg::RW;
  localparam int PW = eswm_pkg::PW;

  logic [4:0] v_r;

  // Stage 1: pairwise trig products.
  logic signed [TW-1:0] sxsy_r, cxsy_r, cycz_r, cysz_r, nsy_r, cxsz_r, cxcz_r;
  logic signed [TW-1:0] sxcy_r, sxsz_r, sxcz_r, cxcy_r, cz1_r, sz1_r;
  eswm_pkg::in_t d1_r;

  // Stage 2: triple products.
  logic signed [TW-1:0] t10_r, t11_r, t20_r, t21_r;
  logic signed [TW-1:0] cycz2_r, cysz2_r, nsy2_r, cxsz2_r, cxcz2_r;
  logic signed [TW-1:0] sxcy2_r, sxsz2_r, sxcz2_r, cxcy2_r;
  eswm_pkg::in_t d2_r;

  // Stage 3: rotation entries.
  logic signed [RW-1:0] r3_r [9];
  eswm_pkg::in_t d3_r;

  // Stage 4: scaled products.
  logic signed [PW-1:0] p4_r [9];
  eswm_pkg::in_t d4_r;

  // Stage 5: output.
  eswm_pkg::out_t o_r;

  logic signed [15:0] ks [9];

  always_comb begin
    ks[0] = d3_r.scale_x;
    ks[1] = d3_r.scale_x;
    ks[2] = d3_r.scale_x;
    ks[3] = d3_r.scale_y;
    ks[4] = d3_r.scale_y;
    ks[5] = d3_r.scale_y;
    ks[6] = d3_r.scale_z;
    ks[7] = d3_r.scale_z;
    ks[8] = d3_r.scale_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sxsy_r <= eswm_pkg::mulq(in_trig.sx, in_trig.sy);
      cxsy_r <= eswm_pkg::mulq(in_trig.cx, in_trig.sy);
      cycz_r <= eswm_pkg::mulq(in_trig.cy, in_trig.cz);
      cysz_r <= eswm_pkg::mulq(in_trig.cy, in_trig.sz);
      nsy_r  <= -in_trig.sy;
      cxsz_r <= eswm_pkg::mulq(in_trig.cx, in_trig.sz);
      cxcz_r <= eswm_pkg::mulq(in_trig.cx, in_trig.cz);
      sxcy_r <= eswm_pkg::mulq(in_trig.sx, in_trig.cy);
      sxsz_r <= eswm_pkg::mulq(in_trig.sx, in_trig.sz);
      sxcz_r <= eswm_pkg::mulq(in_trig.sx, in_trig.cz);
      cxcy_r <= eswm_pkg::mulq(in_trig.cx, in_trig.cy);
      cz1_r  <= in_trig.cz;
      sz1_r  <= in_trig.sz;
      d1_r   <= in_data;

      t10_r   <= eswm_pkg::mulq(sxsy_r, cz1_r);
      t11_r   <= eswm_pkg::mulq(sxsy_r, sz1_r);
      t20_r   <= eswm_pkg::mulq(cxsy_r, cz1_r);
      t21_r   <= eswm_pkg::mulq(cxsy_r, sz1_r);
      cycz2_r <= cycz_r;
      cysz2_r <= cysz_r;
      nsy2_r  <= nsy_r;
      cxsz2_r <= cxsz_r;
      cxcz2_r <= cxcz_r;
      sxcy2_r <= sxcy_r;
      sxsz2_r <= sxsz_r;
      sxcz2_r <= sxcz_r;
      cxcy2_r <= cxcy_r;
      d2_r    <= d1_r;

      r3_r[0] <= RW'(cycz2_r);
      r3_r[1] <= RW'(cysz2_r);
      r3_r[2] <= RW'(nsy2_r);
      r3_r[3] <= RW'(t10_r) - RW'(cxsz2_r);
      r3_r[4] <= RW'(t11_r) + RW'(cxcz2_r);
      r3_r[5] <= RW'(sxcy2_r);
      r3_r[6] <= RW'(t20_r) + RW'(sxsz2_r);
      r3_r[7] <= RW'(t21_r) - RW'(sxcz2_r);
      r3_r[8] <= RW'(cxcy2_r);
      d3_r    <= d2_r;

      for (int j = 0; j < 9; j++) begin
        p4_r[j] <= PW'(ks[j]) * PW'(r3_r[j]);
      end
      d4_r <= d3_r;

      o_r.m00        <= eswm_pkg::sat32(p4_r[0]);
      o_r.m01        <= eswm_pkg::sat32(p4_r[1]);
      o_r.m02        <= eswm_pkg::sat32(p4_r[2]);
      o_r.m10        <= eswm_pkg::sat32(p4_r[3]);
      o_r.m11        <= eswm_pkg::sat32(p4_r[4]);
      o_r.m12        <= eswm_pkg::sat32(p4_r[5]);
      o_r.m20        <= eswm_pkg::sat32(p4_r[6]);
      o_r.m21        <= eswm_pkg::sat32(p4_r[7]);
      o_r.m22        <= eswm_pkg::sat32(p4_r[8]);
      o_r.out_move_x <= d4_r.move_x;
      o_r.out_move_y <= d4_r.move_y;
      o_r.out_move_z <= d4_r.move_z;
    end
  end

  // Valid bits for the five stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  assign out_valid = v_r[4];
  assign out_data  = o_r;

endmodule

// File: rtl/core/euler_srt_world_matrix.sv
// Scale-rotate-translate world matrix builder, top level.
// Instantiates eswm_trig and eswm_mat; depends on eswm_pkg.
//
// Usage: each transfer on the in_ channel carries three Q8.8 axis scales,
// three binary Euler angles and a Q16.16 translation. Each produces exactly
// one transfer on the out_ channel with the nine scaled rotation entries
// (Q16.16, saturated) and the translation passed through.
// The path from input transfer to out_valid holds 30 CORDIC stages, one
// quadrant/rounding stage and five matrix stages. Throughput is one item
// per cycle while out_ready does not hold the pipeline; the CORDIC step chain sets the depth.
// The whole pipeline advances together: when out_valid is high and out_ready
// low, every stage holds and in_ready drops, so no item is lost or repeated.
// When the output register is empty, in_ready stays high.
// Reset (synchronous, rst_n low) clears every stage valid bit; data in
// flight is discarded. The block keeps no state between items.
module euler_srt_world_matrix (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  eswm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output eswm_pkg::out_t out_data
);

  logic            en;
  logic            trig_valid;
  eswm_pkg::trig_t trig;
  eswm_pkg::in_t   trig_data;

  // Pipeline advance: the output register is free or being drained.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  eswm_trig u_trig (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid && in_ready),
    .in_data   (in_data),
    .out_valid (trig_valid),
    .out_trig  (trig),
    .out_data  (trig_data)
  );

  eswm_mat u_mat (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (trig_valid),
    .in_trig   (trig),
    .in_data   (trig_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: dv/euler_srt_world_matrix_tb.sv
// Self-checking testbench for the scale-rotate-translate world matrix block.
// Depends on eswm_pkg (payload types) and the euler_srt_world_matrix RTL.
`timescale 1ns / 100ps

module euler_srt_world_matrix_tb;

  localparam int NUM_RANDOM  = 1700;
  localparam int LATENCY     = 36;
  localparam int CYCLE_LIMIT = 200000;

  // CORDIC arctangent table in units of 2^32 per turn.
  localparam longint ATAN_STEP [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  eswm_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  eswm_pkg::out_t out_data;

  eswm_pkg::in_t  pending_items[$];
  eswm_pkg::out_t expected_matrices[$];
  int     error_count;
  int     cycle_count;
  int     in_wait;
  int     out_wait;
  bit     hold_sender;
  bit     in_fired;
  bit     out_fired;

  euler_srt_world_matrix dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Clock generation.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Round half up by adding half and shifting; SystemVerilog >>> on longint floors.
  function automatic longint round_half_up(input longint v, input int s);
    if (s == 0) begin
      return v;
    end
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Cosine and sine of a binary angle via quadrant fold and CORDIC rotation.
  function automatic void angle_to_trig(input logic [15:0] angle, output longint c_o,
                                        output longint s_o);
    logic [31:0] turn;
    longint      x, y, z, dx, dy, c, s, one;
    turn = {angle, 16'd0};
    z = longint'(turn & 32'h3FFF_FFFF);
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_STEP[i];
      end else begin
        x += dx; y -= dy; z += ATAN_STEP[i];
      end
    end
    case (turn[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    one = longint'(1) <<< 14;
    c_o = clamp(round_half_up(c, 16), -one, one);
    s_o = clamp(round_half_up(s, 16), -one, one);
  endfunction

  function automatic longint trig_mul(input longint a, input longint b);
    return round_half_up(a * b, 14);
  endfunction

  function automatic logic [31:0] scale_entry(input logic signed [15:0] k, input longint r);
    longint v;
    v = round_half_up(longint'(k) * r, 6);
    return 32'(clamp(v, -64'sd2147483648, 64'sd2147483647));
  endfunction

  // Expected world matrix for one transform item.
  function automatic eswm_pkg::out_t world_matrix(input eswm_pkg::in_t t);
    eswm_pkg::out_t m;
    longint cx, sx, cy, sy, cz, sz, sxsy, cxsy;
    angle_to_trig(t.angle_x, cx, sx);
    angle_to_trig(t.angle_y, cy, sy);
    angle_to_trig(t.angle_z, cz, sz);
    sxsy = trig_mul(sx, sy);
    cxsy = trig_mul(cx, sy);
    m.m00 = scale_entry(t.scale_x, trig_mul(cy, cz));
    m.m01 = scale_entry(t.scale_x, trig_mul(cy, sz));
    m.m02 = scale_entry(t.scale_x, -sy);
    m.m10 = scale_entry(t.scale_y, trig_mul(sxsy, cz) - trig_mul(cx, sz));
    m.m11 = scale_entry(t.scale_y, trig_mul(sxsy, sz) + trig_mul(cx, cz));
    m.m12 = scale_entry(t.scale_y, trig_mul(sx, cy));
    m.m20 = scale_entry(t.scale_z, trig_mul(cxsy, cz) + trig_mul(sx, sz));
    m.m21 = scale_entry(t.scale_z, trig_mul(cxsy, sz) - trig_mul(sx, cz));
    m.m22 = scale_entry(t.scale_z, trig_mul(cx, cy));
    m.out_move_x = t.move_x;
    m.out_move_y = t.move_y;
    m.out_move_z = t.move_z;
    return m;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", field, got, want,
             cycle_count);
    error_count++;
  endtask

  function automatic eswm_pkg::in_t random_transform();
    eswm_pkg::in_t t;
    t.scale_x = 16'($urandom);
    t.scale_y = 16'($urandom);
    t.scale_z = 16'($urandom);
    // Mostly small scales within [-2, 2], sometimes the full range.
    if ($urandom_range(0, 3) != 0) begin
      t.scale_x = 16'($signed($urandom_range(0, 1024)) - 512);
      t.scale_y = 16'($signed($urandom_range(0, 1024)) - 512);
      t.scale_z = 16'($signed($urandom_range(0, 1024)) - 512);
    end
    t.angle_x = 16'($urandom);
    t.angle_y = 16'($urandom);
    t.angle_z = 16'($urandom);
    // The x and y angles exactly on quadrant boundaries now and then.
    if ($urandom_range(0, 7) == 0) begin
      t.angle_x = {2'($urandom_range(0, 3)), 14'd0};
      t.angle_y = {2'($urandom_range(0, 3)), 14'd0};
    end
    t.move_x = $urandom;
    t.move_y = $urandom;
    t.move_z = $urandom;
    return t;
  endfunction

  // Driver: pulls items from the pending queue with random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fired) begin
      // Hold the payload until the transfer happens.
    end else if (in_wait > 0) begin
      in_valid <= 1'b0;
      in_wait  <= in_wait - 1;
    end else if (pending_items.size() > 0 && !hold_sender) begin
      in_valid <= 1'b1;
      in_data  <= pending_items.pop_front();
      in_wait  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver backpressure, redrawn after each transfer.
  always @(negedge clk) begin : rx_side
    int draw;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_wait  <= 0;
    end else if (out_fired) begin
      draw = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
      out_ready <= (draw == 0);
      out_wait  <= (draw == 0) ? 0 : draw - 1;
    end else if (out_wait > 0) begin
      out_ready <= 1'b0;
      out_wait  <= out_wait - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predicts on input transfers and checks output transfers.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_fired    <= rst_n && in_valid && in_ready;
    out_fired   <= rst_n && out_valid && out_ready;
    if (rst_n && in_valid && in_ready) begin
      expected_matrices.push_back(world_matrix(in_data));
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_matrices.size() == 0) begin
        $display("unexpected result transfer at cycle %0d", cycle_count);
        error_count++;
      end else begin
        eswm_pkg::out_t want;
        want = expected_matrices.pop_front();
        if (out_data.m00 !== want.m00) report_mismatch("m00", out_data.m00, want.m00);
        if (out_data.m01 !== want.m01) report_mismatch("m01", out_data.m01, want.m01);
        if (out_data.m02 !== want.m02) report_mismatch("m02", out_data.m02, want.m02);
        if (out_data.m10 !== want.m10) report_mismatch("m10", out_data.m10, want.m10);
        if (out_data.m11 !== want.m11) report_mismatch("m11", out_data.m11, want.m11);
        if (out_data.m12 !== want.m12) report_mismatch("m12", out_data.m12, want.m12);
        if (out_data.m20 !== want.m20) report_mismatch("m20", out_data.m20, want.m20);
        if (out_data.m21 !== want.m21) report_mismatch("m21", out_data.m21, want.m21);
        if (out_data.m22 !== want.m22) report_mismatch("m22", out_data.m22, want.m22);
        if (out_data.out_move_x !== want.out_move_x)
          report_mismatch("out_move_x", out_data.out_move_x, want.out_move_x);
        if (out_data.out_move_y !== want.out_move_y)
          report_mismatch("out_move_y", out_data.out_move_y, want.out_move_y);
        if (out_data.out_move_z !== want.out_move_z)
          report_mismatch("out_move_z", out_data.out_move_z, want.out_move_z);
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stimulus and end of test.
  initial begin
    eswm_pkg::in_t t;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    in_wait       = 0;
    hold_sender   = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero, quadrant boundaries, extreme scales and moves.
    for (int q = 0; q < 8; q++) begin
      t = '0;
      t.scale_x = 16'sh0100;
      t.scale_y = 16'sh0100;
      t.scale_z = 16'sh0100;
      t.angle_x = 16'(q * 8192);
      t.angle_y = 16'((q * 8192) + 4096);
      t.angle_z = 16'(65536 - q * 8192);
      t.move_x  = 32'sh7FFF_FFFF;
      t.move_y  = 32'sh8000_0000;
      t.move_z  = 32'hFFFF_FFFF;
      pending_items.push_back(t);
    end
    t = '0;
    t.scale_x = 16'sh7FFF; t.scale_y = 16'sh8000; t.scale_z = 16'sh7FFF;
    t.angle_x = 16'hFFFF; t.angle_y = 16'hFFFF; t.angle_z = 16'hFFFF;
    pending_items.push_back(t);
    t.scale_x = 16'sh8000; t.scale_y = 16'sh7FFF; t.scale_z = 16'sh8000;
    t.angle_x = 16'h4000; t.angle_y = 16'hC000; t.angle_z = 16'h8000;
    t.move_x = '0; t.move_y = 32'sh7FFF_FFFF; t.move_z = 32'sh8000_0000;
    pending_items.push_back(t);
    t.scale_x = 16'hFFFF; t.scale_y = 16'h0001; t.scale_z = 16'hFFFF;
    t.angle_x = 16'h0001; t.angle_y = 16'h2000; t.angle_z = 16'hE000;
    pending_items.push_back(t);
    while (pending_items.size() > 0) @(posedge clk);

    // Let the pipeline drain completely before the random phase.
    hold_sender = 1'b1;
    while (expected_matrices.size() > 0 || in_valid) @(posedge clk);
    hold_sender = 1'b0;

    // Random phase, with bursts queued so back-to-back transfers also occur.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      pending_items.push_back(random_transform());
      if (pending_items.size() > 16) begin
        while (pending_items.size() > 4) @(posedge clk);
      end
    end
    while (pending_items.size() > 0 || in_valid) @(posedge clk);

    while (expected_matrices.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
